### hw/rtl/ssc_pkg.sv
// Package for the silhouette segment chainer.
// Sizes, field widths and storage word layouts; no dependencies.
`default_nettype none
package ssc_pkg;
  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int GRP_DEPTH    = MAX_SEGMENTS + 1;
  localparam int GRP_W        = $clog2(GRP_DEPTH);
  localparam int COORD_W      = 16;
  localparam int PT_W         = 4 * COORD_W;
  localparam int OFF_W        = 8;
  localparam int THR_W        = 34;
  localparam int DIST_W       = 33;
  localparam int SEGINFO_W    = 7 + OFF_W;
  localparam int GRPINFO_W    = 7 + OFF_W;
  localparam logic [THR_W-1:0] THR_RESET = 34'd8053064;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  typedef struct packed {
    logic [DIST_W-1:0] sl;
    logic [DIST_W-1:0] el;
    logic [DIST_W-1:0] er;
    logic [DIST_W-1:0] sr;
  } dist4_t;
endpackage
`default_nettype wire

### hw/rtl/silhouette_segment_chainer.sv
// Top level of the silhouette segment chainer: load, chain and report FSM.
// Depends on ssc_pkg, ssc_ram and ssc_dist.
//
//  channel | ports                                   | handshake
//  input   | in_start_x/y in_end_x/y in_last_segment | start && !busy
//  result  | out_* fields                            | out_valid, one cycle
//  config  | cfg_wdata (join_distance_sq)            | cfg_we
//
// Loading accepts one segment per cycle while start is high and busy is low.
// Chaining runs a seed scan over the indices, with a read to fetch each new
// seed, and, per growth round, a full pass over the endpoint RAM with a read,
// difference, square and compare step per stored segment, then a close step.
// Each result then passes a segment RAM read, a group RAM read and an emit
// step. Reset is synchronous and clears control state only; busy is high
// from the last segment until the final result is on the ports.
// The receiver cannot stall; results are never held off.
`default_nettype none
module silhouette_segment_chainer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [ssc_pkg::COORD_W-1:0] in_start_x,
  input  wire logic signed [ssc_pkg::COORD_W-1:0] in_start_y,
  input  wire logic signed [ssc_pkg::COORD_W-1:0] in_end_x,
  input  wire logic signed [ssc_pkg::COORD_W-1:0] in_end_y,
  input  wire logic                              in_last_segment,
  input  wire logic                              cfg_we,
  input  wire logic [ssc_pkg::THR_W-1:0]         cfg_wdata,
  output logic                                   out_valid,
  output logic [5:0]                             out_segment_index,
  output logic [6:0]                             out_group_id,
  output logic [5:0]                             out_rank,
  output logic [6:0]                             out_group_size,
  output logic                                   out_overflow,
  output logic                                   out_last_result
);
  import ssc_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEED, ST_SEED_RD, ST_SC_RD, ST_SC1, ST_SC2, ST_SC3, ST_SC_END,
    ST_OA, ST_OB, ST_OC
  } state_t;

  state_t                 state_r;
  logic [THR_W-1:0]       thr_r;
  logic [CNT_W-1:0]       cnt_r, i_r, j_r, k_r;
  logic                   ovf_r;
  logic [MAX_SEGMENTS-1:0] grouped_r;
  logic [GRP_W-1:0]       gid_r;
  logic signed [OFF_W-1:0] loff_r, roff_r, minoff_r;
  logic [6:0]             total_r;
  pt_t                    lpt_r, rpt_r, bpt_r;
  seg_t                   cand_r;
  logic                   found_r, bside_r;
  logic [DIST_W-1:0]      best_r;
  logic [IDX_W-1:0]       bseg_r;
  logic [SEGINFO_W-1:0]   seg_info_r;

  logic                   ep_we, si_we, gi_we;
  logic [IDX_W-1:0]       ep_raddr, si_waddr;
  logic [SEGINFO_W-1:0]   si_wdata, si_rdata;
  logic [GRPINFO_W-1:0]   gi_rdata;
  logic [GRP_W-1:0]       gi_raddr;
  logic [PT_W-1:0]        ep_rdata;
  seg_t                   ep_seg;
  dist4_t                 cand_dist;

  logic                   hit;
  logic [DIST_W-1:0]      hit_d;
  logic                   hit_side, hit_nend;
  logic                   accept;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_LOAD);
  assign ep_seg = seg_t'(ep_rdata);

  ssc_ram #(.WIDTH(PT_W), .DEPTH(MAX_SEGMENTS)) u_ep_ram (
    .clk(clk), .we(ep_we), .waddr(cnt_r[IDX_W-1:0]),
    .wdata({in_start_x, in_start_y, in_end_x, in_end_y}),
    .raddr(ep_raddr), .rdata(ep_rdata)
  );

  ssc_ram #(.WIDTH(SEGINFO_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk(clk), .we(si_we), .waddr(si_waddr), .wdata(si_wdata),
    .raddr(k_r[IDX_W-1:0]), .rdata(si_rdata)
  );

  ssc_ram #(.WIDTH(GRPINFO_W), .DEPTH(GRP_DEPTH)) u_grp_ram (
    .clk(clk), .we(gi_we), .waddr(gid_r), .wdata({total_r, minoff_r}),
    .raddr(gi_raddr), .rdata(gi_rdata)
  );

  ssc_dist u_dist (
    .clk(clk), .cand(ep_seg), .lpt(lpt_r), .rpt(rpt_r), .dist_o(cand_dist)
  );

  always_comb begin
    ep_we    = (state_r == ST_LOAD) && accept && (cnt_r < CNT_W'(MAX_SEGMENTS));
    ep_raddr = (state_r == ST_SEED) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
    si_we    = 1'b0;
    si_waddr = i_r[IDX_W-1:0];
    si_wdata = {7'(gid_r), OFF_W'(0)};
    if (state_r == ST_SEED && !grouped_r[i_r[IDX_W-1:0]] && i_r != cnt_r) begin
      si_we = 1'b1;
    end else if (state_r == ST_SC_END && found_r) begin
      si_we    = 1'b1;
      si_waddr = bseg_r;
      si_wdata = {7'(gid_r), (bside_r ? roff_r + OFF_W'(1) : loff_r - OFF_W'(1))};
    end
    gi_we    = (state_r == ST_SC_END) && !found_r;
    gi_raddr = GRP_W'(si_rdata[SEGINFO_W-1:OFF_W]);
  end

  // first test within threshold, in start-left, end-left, end-right, start-right order
  always_comb begin
    hit      = 1'b1;
    hit_d    = cand_dist.sl;
    hit_side = 1'b0;
    hit_nend = 1'b1;
    if ({1'b0, cand_dist.sl} <= thr_r) begin
      hit_d = cand_dist.sl; hit_side = 1'b0; hit_nend = 1'b1;
    end else if ({1'b0, cand_dist.el} <= thr_r) begin
      hit_d = cand_dist.el; hit_side = 1'b0; hit_nend = 1'b0;
    end else if ({1'b0, cand_dist.er} <= thr_r) begin
      hit_d = cand_dist.er; hit_side = 1'b1; hit_nend = 1'b0;
    end else if ({1'b0, cand_dist.sr} <= thr_r) begin
      hit_d = cand_dist.sr; hit_side = 1'b1; hit_nend = 1'b1;
    end else begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_r < CNT_W'(MAX_SEGMENTS)) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
          if (in_last_segment) begin
            i_r     <= '0;
            gid_r   <= GRP_W'(1);
            state_r <= ST_SEED;
          end
        end
      end
      ST_SEED: begin
        if (i_r == cnt_r) begin
          k_r     <= '0;
          state_r <= ST_OA;
        end else if (grouped_r[i_r[IDX_W-1:0]]) begin
          i_r <= i_r + CNT_W'(1);
        end else begin
          grouped_r[i_r[IDX_W-1:0]] <= 1'b1;
          loff_r   <= '0;
          roff_r   <= '0;
          minoff_r <= '0;
          total_r  <= 7'd1;
          state_r  <= ST_SEED_RD;
        end
      end
      ST_SEED_RD: begin
        lpt_r   <= '{x: ep_seg.sx, y: ep_seg.sy};
        rpt_r   <= '{x: ep_seg.ex, y: ep_seg.ey};
        j_r     <= '0;
        found_r <= 1'b0;
        state_r <= ST_SC_RD;
      end
      ST_SC_RD: state_r <= ST_SC1;
      ST_SC1: begin
        cand_r  <= ep_seg;
        state_r <= ST_SC2;
      end
      ST_SC2: state_r <= ST_SC3;
      ST_SC3: begin
        if (!grouped_r[j_r[IDX_W-1:0]] && hit && (!found_r || hit_d < best_r)) begin
          found_r <= 1'b1;
          best_r  <= hit_d;
          bseg_r  <= j_r[IDX_W-1:0];
          bside_r <= hit_side;
          bpt_r   <= hit_nend ? '{x: cand_r.ex, y: cand_r.ey}
                              : '{x: cand_r.sx, y: cand_r.sy};
        end
        if (j_r + CNT_W'(1) == cnt_r) begin
          state_r <= ST_SC_END;
        end else begin
          j_r     <= j_r + CNT_W'(1);
          state_r <= ST_SC_RD;
        end
      end
      ST_SC_END: begin
        if (found_r) begin
          grouped_r[bseg_r] <= 1'b1;
          total_r <= total_r + 7'd1;
          if (bside_r) begin
            roff_r <= roff_r + OFF_W'(1);
            rpt_r  <= bpt_r;
          end else begin
            loff_r   <= loff_r - OFF_W'(1);
            minoff_r <= loff_r - OFF_W'(1);
            lpt_r    <= bpt_r;
          end
          j_r     <= '0;
          found_r <= 1'b0;
          state_r <= ST_SC_RD;
        end else begin
          gid_r   <= gid_r + GRP_W'(1);
          i_r     <= i_r + CNT_W'(1);
          state_r <= ST_SEED;
        end
      end
      ST_OA: state_r <= ST_OB;
      ST_OB: begin
        seg_info_r <= si_rdata;
        state_r    <= ST_OC;
      end
      ST_OC: begin
        out_valid         <= 1'b1;
        out_segment_index <= k_r[5:0];
        out_group_id      <= seg_info_r[SEGINFO_W-1:OFF_W];
        out_rank          <= 6'(seg_info_r[OFF_W-1:0] - gi_rdata[OFF_W-1:0]);
        out_group_size    <= gi_rdata[GRPINFO_W-1:OFF_W];
        out_overflow      <= ovf_r;
        out_last_result   <= (k_r + CNT_W'(1) == cnt_r);
        if (k_r + CNT_W'(1) == cnt_r) begin
          cnt_r     <= '0;
          ovf_r     <= 1'b0;
          grouped_r <= '0;
          state_r   <= ST_LOAD;
        end else begin
          k_r     <= k_r + CNT_W'(1);
          state_r <= ST_OA;
        end
      end
      default: state_r <= ST_LOAD;
    endcase
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      thr_r     <= THR_RESET;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      grouped_r <= '0;
      found_r   <= 1'b0;
      out_valid <= 1'b0;
    end
  end

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_OC)) else $error("result without emit");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SEGMENTS)) else $error("segment count out of range");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SC3) |-> (cnt_r != '0) && (j_r < cnt_r)) else $error("bad scan index");
  a_join_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SC_END && found_r) |=> grouped_r[$past(bseg_r)])
    else $error("joined segment not marked");
endmodule
`default_nettype wire

### hw/rtl/ssc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/ssc_dist.sv
// Two-stage squared-distance unit: candidate endpoints against chain ends.
// Depends on ssc_pkg.
`default_nettype none
module ssc_dist (
  input  wire logic          clk,
  input  wire ssc_pkg::seg_t cand,
  input  wire ssc_pkg::pt_t  lpt,
  input  wire ssc_pkg::pt_t  rpt,
  output ssc_pkg::dist4_t    dist_o
);
  import ssc_pkg::*;

  logic signed [COORD_W:0] dx_r [4];
  logic signed [COORD_W:0] dy_r [4];
  logic [DIST_W-1:0]       sq   [4];
  logic signed [2*COORD_W+1:0] px [4];
  logic signed [2*COORD_W+1:0] py [4];

  always_ff @(posedge clk) begin
    dx_r[0] <= {cand.sx[COORD_W-1], cand.sx} - {lpt.x[COORD_W-1], lpt.x};
    dy_r[0] <= {cand.sy[COORD_W-1], cand.sy} - {lpt.y[COORD_W-1], lpt.y};
    dx_r[1] <= {cand.ex[COORD_W-1], cand.ex} - {lpt.x[COORD_W-1], lpt.x};
    dy_r[1] <= {cand.ey[COORD_W-1], cand.ey} - {lpt.y[COORD_W-1], lpt.y};
    dx_r[2] <= {cand.ex[COORD_W-1], cand.ex} - {rpt.x[COORD_W-1], rpt.x};
    dy_r[2] <= {cand.ey[COORD_W-1], cand.ey} - {rpt.y[COORD_W-1], rpt.y};
    dx_r[3] <= {cand.sx[COORD_W-1], cand.sx} - {rpt.x[COORD_W-1], rpt.x};
    dy_r[3] <= {cand.sy[COORD_W-1], cand.sy} - {rpt.y[COORD_W-1], rpt.y};
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px[k] = dx_r[k] * dx_r[k];
      py[k] = dy_r[k] * dy_r[k];
      sq[k] = {1'b0, px[k][2*COORD_W-1:0]} + {1'b0, py[k][2*COORD_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    dist_o.sl <= sq[0];
    dist_o.el <= sq[1];
    dist_o.er <= sq[2];
    dist_o.sr <= sq[3];
  end
endmodule
`default_nettype wire
